@@ hdl/frbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package frbp_pkg;

	// Default pool geometry.
	localparam int BUCKETS_DEF          = 3;
	localparam int SLOTS_PER_BUCKET_DEF = 16;

	// Fixed field widths.
	localparam int FRAME_W   = 16;
	localparam int HANDLE_W  = 6;
	localparam int COUNT_W   = 6;
	localparam int USAGE_W   = 32;
	localparam int DIMS_W    = 42;
	localparam int KEY_W     = DIMS_W + USAGE_W;

	// Function codes.
	localparam logic [1:0] FUNC_BEGIN   = 2'd0;
	localparam logic [1:0] FUNC_ACQUIRE = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;

	// Status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_CREATED = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;
	localparam logic [1:0] STATUS_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [FRAME_W-1:0] frame_index;
		logic [7:0]         tex_format;
		logic [14:0]        tex_width;
		logic [14:0]        tex_height;
		logic [3:0]         mip_levels;
		logic [USAGE_W-1:0] usage_flags;
		logic [HANDLE_W-1:0] slot_handle;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] granted_handle;
		logic [COUNT_W-1:0]  total_slots;
		logic [COUNT_W-1:0]  busy_slots;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_BEGIN,
		ST_SCAN,
		ST_REL
	} state_t;

	// Key as stored in the slot memory: dimensions above usage mask.
	function automatic logic [KEY_W-1:0] pack_key(input cmd_t c);
		pack_key = {c.tex_format, c.tex_width, c.tex_height, c.mip_levels, c.usage_flags};
	endfunction

endpackage

`default_nettype wire

@@ hdl/frame_bucketed_resource_pool.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports            Handshake                      Payload
// command   start, busy      taken when start && !busy      cmd   (frbp_pkg::cmd_t)
// result    done             one-cycle strobe, no backpressure rsp (frbp_pkg::rsp_t)
//
// Begin frame: a reciprocal multiply at accept gives the quotient, ST_MOD forms
// the remainder, then ST_BEGIN clears the bucket. Acquire reads the bucket's slots
// in order until a hit on a free slot with the same key, or past the last filled
// slot for a miss; an invalid descriptor or an empty bucket is answered without a
// read. Release and unknown codes pass through ST_REL. One item is in work at a
// time and the receiver cannot stall. Reset clears all in-use marks and fill
// counts at once.

module frame_bucketed_resource_pool #(
	parameter int BUCKETS          = frbp_pkg::BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = frbp_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire frbp_pkg::cmd_t cmd,
	output logic               done,
	output frbp_pkg::rsp_t     rsp
);

	localparam int NSLOTS = BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW     = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int CW     = $clog2(NSLOTS + 1);
	localparam int XW     = (CW > frbp_pkg::HANDLE_W) ? CW : frbp_pkg::HANDLE_W;
	localparam int KW     = frbp_pkg::KEY_W;
	localparam int HW     = frbp_pkg::HANDLE_W;
	localparam int OCW    = frbp_pkg::COUNT_W;
	localparam int FRW    = frbp_pkg::FRAME_W;
	// Reciprocal of the bucket count, exact for every frame index.
	localparam int RK     = FRW + 4;
	localparam int PW     = FRW + RK;
	localparam int RECIP_I = ((1 << RK) + BUCKETS - 1) / BUCKETS;
	localparam logic [RK:0] RECIP = (RK + 1)'(RECIP_I);

	frbp_pkg::state_t state_q, state_nxt;

	frbp_pkg::cmd_t cmd_q;
	frbp_pkg::rsp_t rsp_q;
	logic           done_q;

	logic [BW-1:0]     cur_q;
	logic [FW-1:0]     fill_q [BUCKETS];
	logic [FW-1:0]     bbusy_q [BUCKETS];
	logic [NSLOTS-1:0] busy_bits_q;
	logic [CW-1:0]     total_q;
	logic [CW-1:0]     bcnt_q;
	logic [FW-1:0]     scan_idx_q;
	logic [FRW-1:0]    mod_quo_q;
	logic [BW-1:0]     mod_r_q;

	// Key memory and its read pipeline.
	logic [KW-1:0] key_mem [NSLOTS];
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	logic [KW-1:0] rd_key_s1;

	logic          accept;
	logic [AW-1:0] cur_base;
	logic [FW-1:0] fill_cur;
	logic [KW-1:0] key_req;
	logic          invalid_req;
	logic          scan_more;
	logic          hit_s1;
	logic          bucket_full;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] new_addr;
	logic          rel_in_range;
	logic [AW-1:0] rel_addr;
	logic [BW-1:0] rel_bk;
	logic [FRW-1:0] mod_quo;
	logic [FRW-1:0] mod_diff;
	logic [BW-1:0] mod_r_nxt;

	logic          reply;
	logic [1:0]    reply_status;
	logic [AW-1:0] reply_addr;
	logic          reply_has_handle;
	logic          acq_hit;
	logic          acq_new;
	logic          rd_issue;
	logic          rel_clear;
	logic          begin_clear;

	logic [CW-1:0] total_nxt;
	logic [CW-1:0] bcnt_nxt;

	assign busy   = (state_q != frbp_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Address arithmetic for the current bucket.
	assign cur_base    = AW'(AW'(cur_q) * AW'(SLOTS_PER_BUCKET));
	assign fill_cur    = fill_q[cur_q];
	assign key_req     = frbp_pkg::pack_key(cmd_q);
	assign invalid_req = (cmd_q.tex_format == '0) || (cmd_q.tex_width == '0) ||
		(cmd_q.tex_height == '0) || (cmd_q.mip_levels == '0);
	assign scan_more   = (scan_idx_q < fill_cur);
	assign bucket_full = (fill_cur >= FW'(SLOTS_PER_BUCKET));
	assign rd_addr     = AW'(cur_base + AW'(scan_idx_q));
	assign new_addr    = AW'(cur_base + AW'(fill_cur));

	// A slot read last cycle matches when its key is equal and it is free.
	assign hit_s1 = rd_vld_s1 && (rd_key_s1 == key_req) && !busy_bits_q[rd_addr_s1];

	// Release target and its bucket.
	assign rel_in_range = (XW'(cmd_q.slot_handle) < XW'(NSLOTS));
	assign rel_addr     = AW'(cmd_q.slot_handle);

	always_comb begin
		rel_bk = '0;
		for (int b = 1; b < BUCKETS; b++) begin
			if (XW'(cmd_q.slot_handle) >= XW'(b * SLOTS_PER_BUCKET)) begin
				rel_bk = BW'(b);
			end
		end
	end

	// Frame index modulo the bucket count: the quotient is registered with the item,
	// the remainder in the ST_MOD state that follows.
	assign mod_quo   = FRW'((PW'(cmd.frame_index) * PW'(RECIP)) >> RK);
	assign mod_diff  = cmd_q.frame_index - FRW'(mod_quo_q * FRW'(BUCKETS));
	assign mod_r_nxt = BW'(mod_diff);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			frbp_pkg::ST_IDLE: begin
				if (accept) begin
					priority case (cmd.func)
						frbp_pkg::FUNC_BEGIN:   state_nxt = frbp_pkg::ST_MOD;
						frbp_pkg::FUNC_ACQUIRE: state_nxt = frbp_pkg::ST_SCAN;
						default:                state_nxt = frbp_pkg::ST_REL;
					endcase
				end
			end
			frbp_pkg::ST_MOD:   state_nxt = frbp_pkg::ST_BEGIN;
			frbp_pkg::ST_BEGIN: state_nxt = frbp_pkg::ST_IDLE;
			frbp_pkg::ST_REL:   state_nxt = frbp_pkg::ST_IDLE;
			frbp_pkg::ST_SCAN: begin
				if (invalid_req || hit_s1 || (!scan_more && !rd_vld_s1)) begin
					state_nxt = frbp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = frbp_pkg::ST_IDLE;
		endcase
	end

	// Actions per state.
	always_comb begin
		reply            = 1'b0;
		reply_status     = frbp_pkg::STATUS_OK;
		reply_addr       = '0;
		reply_has_handle = 1'b0;
		acq_hit          = 1'b0;
		acq_new          = 1'b0;
		rd_issue         = 1'b0;
		rel_clear        = 1'b0;
		begin_clear      = 1'b0;
		unique case (state_q)
			frbp_pkg::ST_BEGIN: begin
				reply       = 1'b1;
				begin_clear = 1'b1;
			end
			frbp_pkg::ST_REL: begin
				reply     = 1'b1;
				rel_clear = (cmd_q.func == frbp_pkg::FUNC_RELEASE) && rel_in_range &&
					busy_bits_q[rel_addr];
			end
			frbp_pkg::ST_SCAN: begin
				priority if (invalid_req) begin
					reply        = 1'b1;
					reply_status = frbp_pkg::STATUS_INVALID;
				end else if (hit_s1) begin
					reply            = 1'b1;
					reply_addr       = rd_addr_s1;
					reply_has_handle = 1'b1;
					acq_hit          = 1'b1;
				end else if (!scan_more && !rd_vld_s1) begin
					reply = 1'b1;
					if (bucket_full) begin
						reply_status = frbp_pkg::STATUS_FULL;
					end else begin
						reply_status     = frbp_pkg::STATUS_CREATED;
						reply_addr       = new_addr;
						reply_has_handle = 1'b1;
						acq_new          = 1'b1;
					end
				end else begin
					rd_issue = scan_more;
				end
			end
			default: begin
			end
		endcase
	end

	// Running totals after this item.
	always_comb begin
		total_nxt = total_q;
		bcnt_nxt  = bcnt_q;
		if (acq_new) begin
			total_nxt = total_q + CW'(1);
		end
		priority if (acq_hit || acq_new) begin
			bcnt_nxt = bcnt_q + CW'(1);
		end else if (rel_clear) begin
			bcnt_nxt = bcnt_q - CW'(1);
		end else if (begin_clear) begin
			bcnt_nxt = bcnt_q - CW'(bbusy_q[mod_r_q]);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frbp_pkg::ST_IDLE;
			done_q      <= 1'b0;
			cur_q       <= '0;
			busy_bits_q <= '0;
			total_q     <= '0;
			bcnt_q      <= '0;
			scan_idx_q  <= '0;
			mod_r_q     <= '0;
			rd_vld_s1   <= 1'b0;
			for (int b = 0; b < BUCKETS; b++) begin
				fill_q[b]  <= '0;
				bbusy_q[b] <= '0;
			end
		end else begin
			state_q   <= state_nxt;
			done_q    <= reply;
			rd_vld_s1 <= rd_issue;
			total_q   <= total_nxt;
			bcnt_q    <= bcnt_nxt;

			if (accept) begin
				scan_idx_q <= '0;
			end
			if (state_q == frbp_pkg::ST_MOD) begin
				mod_r_q <= mod_r_nxt;
			end
			if (rd_issue) begin
				scan_idx_q <= scan_idx_q + FW'(1);
			end

			if (acq_hit) begin
				busy_bits_q[rd_addr_s1] <= 1'b1;
				bbusy_q[cur_q]          <= bbusy_q[cur_q] + FW'(1);
			end
			if (acq_new) begin
				busy_bits_q[new_addr] <= 1'b1;
				bbusy_q[cur_q]        <= bbusy_q[cur_q] + FW'(1);
				fill_q[cur_q]         <= fill_cur + FW'(1);
			end
			if (rel_clear) begin
				busy_bits_q[rel_addr] <= 1'b0;
				bbusy_q[rel_bk]       <= bbusy_q[rel_bk] - FW'(1);
			end
			if (begin_clear) begin
				cur_q            <= mod_r_q;
				bbusy_q[mod_r_q] <= '0;
				for (int b = 0; b < BUCKETS; b++) begin
					for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
						if (mod_r_q == BW'(b)) begin
							busy_bits_q[b * SLOTS_PER_BUCKET + s] <= 1'b0;
						end
					end
				end
			end
		end
	end

	// Command and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			mod_quo_q <= mod_quo;
		end
		if (rd_issue) begin
			rd_addr_s1 <= rd_addr;
		end
		if (reply) begin
			rsp_q.status         <= reply_status;
			rsp_q.granted_handle <= reply_has_handle ? HW'(reply_addr) : '0;
			rsp_q.total_slots    <= OCW'(total_nxt);
			rsp_q.busy_slots     <= OCW'(bcnt_nxt);
		end
	end

	// Slot key memory: one write, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (acq_new) begin
			key_mem[new_addr] <= key_req;
		end
		if (rd_issue) begin
			rd_key_s1 <= key_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/frbp_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frbp_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire frbp_pkg::cmd_t cmd,
	input wire logic           done,
	input wire frbp_pkg::rsp_t rsp
);

	// Every accepted item puts the block to work.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	// A result appears exactly when work ends.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("work ended without a result");

	a_done_fall: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without finished work");

	// Rejected acquires hand out no slot.
	a_reject_handle: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == frbp_pkg::STATUS_INVALID ||
			rsp.status == frbp_pkg::STATUS_FULL) |-> rsp.granted_handle == '0)
		else $error("rejected acquire returned a handle");

endmodule

bind frame_bucketed_resource_pool frbp_chk u_frbp_chk (.*);

`default_nettype wire

@@ sim/tb_frame_bucketed_resource_pool.sv @@
`timescale 1ns / 1ps

module tb_frame_bucketed_resource_pool;

	localparam int          NB           = frbp_pkg::BUCKETS_DEF;
	localparam int          SPB          = frbp_pkg::SLOTS_PER_BUCKET_DEF;
	localparam int          NSLOT        = NB * SPB;
	localparam int          FRW          = frbp_pkg::FRAME_W;
	localparam int          HW           = frbp_pkg::HANDLE_W;
	localparam int          CNTW         = frbp_pkg::COUNT_W;
	localparam int          UW           = frbp_pkg::USAGE_W;
	localparam int          DW           = frbp_pkg::DIMS_W;
	localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
	localparam int          RAND_ITEMS   = 1900;
	localparam int          CALM_ITEMS   = 200;
	localparam int          KEYS         = 24;
	localparam int          DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	// Tracks the pool contents and holds the results still owed by the block.
	class pool_tracker;
		logic [DW-1:0]   key_dims [NSLOT];
		logic [UW-1:0]   key_usage [NSLOT];
		bit              in_use [NSLOT];
		int              fill [NB];
		int              cur_bucket;
		frbp_pkg::rsp_t  expected_rsps [$];
		int              mismatches;

		function new();
			for (int i = 0; i < NSLOT; i++) begin
				key_dims[i]  = '0;
				key_usage[i] = '0;
				in_use[i]    = 1'b0;
			end
			for (int b = 0; b < NB; b++) begin
				fill[b] = 0;
			end
			cur_bucket = 0;
			mismatches = 0;
		endfunction

		// Apply one accepted item to the pool and queue the result it must give.
		function void note_cmd(frbp_pkg::cmd_t c);
			frbp_pkg::rsp_t r;
			logic [DW-1:0]  dims;
			int             base;
			int             idx;
			bit             hit;
			int             total;
			int             nbusy;
			r = '0;
			case (c.func)
				frbp_pkg::FUNC_BEGIN: begin
					cur_bucket = c.frame_index % NB;
					for (int s = 0; s < SPB; s++) begin
						in_use[cur_bucket * SPB + s] = 1'b0;
					end
				end
				frbp_pkg::FUNC_ACQUIRE: begin
					dims = {c.tex_format, c.tex_width, c.tex_height, c.mip_levels};
					base = cur_bucket * SPB;
					hit  = 1'b0;
					if (c.tex_format == 0 || c.tex_width == 0 || c.tex_height == 0 ||
					    c.mip_levels == 0) begin
						r.status = frbp_pkg::STATUS_INVALID;
					end else begin
						// Lowest free slot with an exact key match wins.
						for (int s = 0; s < fill[cur_bucket] && !hit; s++) begin
							idx = base + s;
							if (!in_use[idx] && key_dims[idx] == dims &&
							    key_usage[idx] == c.usage_flags) begin
								in_use[idx]      = 1'b1;
								r.status         = frbp_pkg::STATUS_OK;
								r.granted_handle = idx[HW-1:0];
								hit              = 1'b1;
							end
						end
						if (!hit) begin
							if (fill[cur_bucket] >= SPB) begin
								r.status = frbp_pkg::STATUS_FULL;
							end else begin
								idx              = base + fill[cur_bucket];
								key_dims[idx]    = dims;
								key_usage[idx]   = c.usage_flags;
								in_use[idx]      = 1'b1;
								fill[cur_bucket] = fill[cur_bucket] + 1;
								r.status         = frbp_pkg::STATUS_CREATED;
								r.granted_handle = idx[HW-1:0];
							end
						end
					end
				end
				frbp_pkg::FUNC_RELEASE: begin
					if (c.slot_handle < NSLOT) begin
						in_use[c.slot_handle] = 1'b0;
					end
				end
				default: begin
				end
			endcase
			// Occupancy counts over the whole pool after the item.
			total = 0;
			nbusy = 0;
			for (int b = 0; b < NB; b++) begin
				total += fill[b];
				for (int s = 0; s < fill[b]; s++) begin
					if (in_use[b * SPB + s]) begin
						nbusy++;
					end
				end
			end
			r.total_slots = total[CNTW-1:0];
			r.busy_slots  = nbusy[CNTW-1:0];
			expected_rsps = {expected_rsps, r};
		endfunction

		// Compare one result from the block with the oldest outstanding one.
		function void check_rsp(frbp_pkg::rsp_t got);
			frbp_pkg::rsp_t want;
			if (expected_rsps.size() == 0) begin
				$error("result with no item outstanding: %h", got);
				mismatches++;
			end else begin
				want = expected_rsps.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					mismatches++;
				end
				if (got.granted_handle !== want.granted_handle) begin
					$error("granted_handle: expected %0d, actual %0d",
					       want.granted_handle, got.granted_handle);
					mismatches++;
				end
				if (got.total_slots !== want.total_slots) begin
					$error("total_slots: expected %0d, actual %0d",
					       want.total_slots, got.total_slots);
					mismatches++;
				end
				if (got.busy_slots !== want.busy_slots) begin
					$error("busy_slots: expected %0d, actual %0d",
					       want.busy_slots, got.busy_slots);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_rsps.size();
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           start;
	logic           busy;
	frbp_pkg::cmd_t cmd;
	logic           done;
	frbp_pkg::rsp_t rsp;
	pool_tracker    tracker;
	int unsigned    cycle_count = 0;
	frbp_pkg::cmd_t key_pool [KEYS];

	frame_bucketed_resource_pool u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Every field random; the caller overrides the ones that matter.
	function automatic frbp_pkg::cmd_t random_cmd(input logic [1:0] f);
		frbp_pkg::cmd_t c;
		c.func        = f;
		c.frame_index = FRW'($urandom);
		c.tex_format  = 8'($urandom);
		c.tex_width   = 15'($urandom_range(0, 16384));
		c.tex_height  = 15'($urandom_range(0, 16384));
		c.mip_levels  = 4'($urandom);
		c.usage_flags = $urandom;
		c.slot_handle = HW'($urandom);
		return c;
	endfunction

	function automatic frbp_pkg::cmd_t acquire_cmd(input logic [7:0] fmt,
	                                               input logic [14:0] w,
	                                               input logic [14:0] h,
	                                               input logic [3:0] mips,
	                                               input logic [UW-1:0] usage);
		frbp_pkg::cmd_t c;
		c             = random_cmd(frbp_pkg::FUNC_ACQUIRE);
		c.tex_format  = fmt;
		c.tex_width   = w;
		c.tex_height  = h;
		c.mip_levels  = mips;
		c.usage_flags = usage;
		return c;
	endfunction

	// Present one item, optionally after an idle burst, and wait until it is taken.
	task automatic issue(input frbp_pkg::cmd_t c, input bit gap_ok);
		int n;
		if (gap_ok && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		cmd   <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Watch both handshakes at every edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				tracker.check_rsp(rsp);
			end
			if (start && !busy) begin
				tracker.note_cmd(cmd);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("frame_bucketed_resource_pool verification failed");
			$finish;
		end
	end

	initial begin
		frbp_pkg::cmd_t c;
		int             sel;
		bit             gaps_on;
		tracker = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		cmd     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: frame index extremes, each invalid field, reuse and the corners.
		c = random_cmd(frbp_pkg::FUNC_BEGIN);
		c.frame_index = 16'hFFFF;
		issue(c, 1'b0);
		issue(acquire_cmd(8'd0, 15'd64, 15'd64, 4'd1, 32'h1), 1'b0);
		issue(acquire_cmd(8'd7, 15'd0, 15'd64, 4'd1, 32'h1), 1'b0);
		issue(acquire_cmd(8'd7, 15'd64, 15'd0, 4'd1, 32'h1), 1'b0);
		issue(acquire_cmd(8'd7, 15'd64, 15'd64, 4'd0, 32'h1), 1'b0);
		issue(acquire_cmd(8'hFF, 15'd16384, 15'd16384, 4'hF, 32'hFFFF_FFFF), 1'b0);
		issue(acquire_cmd(8'hFF, 15'd16384, 15'd16384, 4'hF, 32'hFFFF_FFFF), 1'b0);
		c = random_cmd(frbp_pkg::FUNC_RELEASE);
		c.slot_handle = '0;
		issue(c, 1'b0);
		issue(acquire_cmd(8'hFF, 15'd16384, 15'd16384, 4'hF, 32'hFFFF_FFFF), 1'b0);
		issue(acquire_cmd(8'd1, 15'd1, 15'd1, 4'd1, 32'h0), 1'b0);
		issue(acquire_cmd(8'hFF, 15'd16384, 15'd16384, 4'hF, 32'h7FFF_FFFF), 1'b0);
		c = random_cmd(frbp_pkg::FUNC_RELEASE);
		c.slot_handle = 6'd63;
		issue(c, 1'b0);
		c.slot_handle = 6'd48;
		issue(c, 1'b0);
		issue(random_cmd(FUNC_UNUSED), 1'b0);
		c = random_cmd(frbp_pkg::FUNC_BEGIN);
		c.frame_index = 16'd1;
		issue(c, 1'b0);
		c.frame_index = 16'd2;
		issue(c, 1'b0);
		c.frame_index = 16'd0;
		issue(c, 1'b0);
		issue(acquire_cmd(8'hFF, 15'd16384, 15'd16384, 4'hF, 32'hFFFF_FFFF), 1'b0);

		// A small set of valid keys, some differing from a neighbor in one field only.
		for (int i = 0; i < KEYS; i++) begin
			key_pool[i] = acquire_cmd(8'($urandom_range(1, 255)),
			                          15'($urandom_range(1, 16384)),
			                          15'($urandom_range(1, 16384)),
			                          4'($urandom_range(1, 15)), $urandom);
			if (i > 0 && $urandom_range(0, 2) == 0) begin
				key_pool[i] = key_pool[i - 1];
				if ($urandom_range(0, 1) == 0) begin
					key_pool[i].usage_flags[$urandom_range(0, UW - 1)] ^= 1'b1;
				end else begin
					key_pool[i].mip_levels = (key_pool[i].mip_levels == 4'hF) ?
					                         4'd1 : key_pool[i].mip_levels + 4'd1;
				end
			end
		end

		// Random: mostly pooled acquires between frame starts, plus releases and noise.
		gaps_on = 1'b0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 50 == 0) begin
				gaps_on = ($urandom_range(0, 2) != 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				c = random_cmd(frbp_pkg::FUNC_BEGIN);
			end else if (sel < 67) begin
				c = random_cmd(frbp_pkg::FUNC_ACQUIRE);
				c.tex_format  = key_pool[sel % KEYS].tex_format;
				c             = key_pool[$urandom_range(0, KEYS - 1)];
				c.frame_index = FRW'($urandom);
				c.slot_handle = HW'($urandom);
			end else if (sel < 75) begin
				c = random_cmd(frbp_pkg::FUNC_ACQUIRE);
				case ($urandom_range(0, 5))
					0: c.tex_format = '0;
					1: c.tex_width  = '0;
					2: c.tex_height = '0;
					3: c.mip_levels = '0;
					default: begin
					end
				endcase
			end else if (sel < 97) begin
				c = random_cmd(frbp_pkg::FUNC_RELEASE);
				c.slot_handle = ($urandom_range(0, 9) == 0) ?
				                HW'($urandom_range(NSLOT, 63)) :
				                HW'($urandom_range(0, NSLOT - 1));
			end else begin
				c = random_cmd(FUNC_UNUSED);
			end
			issue(c, gaps_on && n < RAND_ITEMS - CALM_ITEMS);
		end
		start <= 1'b0;

		// Drain the outstanding results, then give stray strobes time to show.
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("frame_bucketed_resource_pool verification clean");
		end else begin
			$display("frame_bucketed_resource_pool verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/frbp_pkg.sv
hdl/frame_bucketed_resource_pool.sv
hdl/frbp_chk.sv
sim/tb_frame_bucketed_resource_pool.sv
